@@ hdl/tmpl_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tmpl_pkg: shared types and codes of the triangle mesh point locator
// Command word layout, result word layout and the item mode codes.
// ----------------------------------------------------------------------------
package tmpl_pkg;

    localparam logic [1:0] MODE_VTX = 2'd0;
    localparam logic [1:0] MODE_TRI = 2'd1;
    localparam logic [1:0] MODE_LOC = 2'd2;

    localparam int SLOT_W  = 10;
    localparam int COORD_W = 16;
    localparam int CNT_W   = 11;

    typedef struct packed {
        logic [1:0]         mode;
        logic [SLOT_W-1:0]  slot;
        logic [COORD_W-1:0] coord_x;
        logic [COORD_W-1:0] coord_y;
        logic [SLOT_W-1:0]  corner_a;
        logic [SLOT_W-1:0]  corner_b;
        logic [SLOT_W-1:0]  corner_c;
    } cmd_t;

    typedef struct packed {
        logic              found;
        logic [SLOT_W-1:0] triangle_index;
    } res_t;

endpackage
`default_nettype wire

@@ hdl/tmpl_fifo.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tmpl_fifo: small synchronous queue
// Register-based first-in first-out queue with a fill count.
// ----------------------------------------------------------------------------
module tmpl_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             pop,
    output logic      [WIDTH-1:0] rdata,
    output logic                  full,
    output logic                  empty
);
    localparam int AW = $clog2(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wptr_reg;
    logic [AW-1:0]    rptr_reg;
    logic [AW:0]      cnt_reg;

    assign full  = (cnt_reg == (AW+1)'(DEPTH));
    assign empty = (cnt_reg == '0);
    assign rdata = mem_reg[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= (wptr_reg == AW'(DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
            end
            if (pop)
            begin
                rptr_reg <= (rptr_reg == AW'(DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    // The fill count never passes the depth.
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= (AW+1)'(DEPTH))
        else $error("queue fill count above depth");

    // The users never write a full queue unless a read of the queue comes with the write.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!full || pop))
        else $error("write into a full queue");

    // A lone read lowers the count by one.
    a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !push) |=> (cnt_reg == $past(cnt_reg) - 1'b1))
        else $error("queue count did not follow a read");

endmodule
`default_nettype wire

@@ hdl/tmpl_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tmpl_front: input side of the point locator
// Accepts words, drops those that do nothing and queues the rest as commands.
// ----------------------------------------------------------------------------
module tmpl_front #(
    parameter int MAX_VERTICES  = 1024,
    parameter int MAX_TRIANGLES = 1024
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    output logic                full,
    input  wire tmpl_pkg::cmd_t in_cmd,
    input  wire logic           cmd_pop,
    output tmpl_pkg::cmd_t      cmd,
    output logic                cmd_empty
);
    import tmpl_pkg::*;

    localparam logic [16:0] VTX_LIM = 17'(MAX_VERTICES);
    localparam logic [16:0] TRI_LIM = 17'(MAX_TRIANGLES);

    logic        keep;
    logic        q_push;
    logic [16:0] slot_ext;

    // Writes aimed past a store and unused modes leave no trace, so they
    // never enter the queue.
    assign slot_ext = {7'b0, in_cmd.slot};

    always_comb
    begin
        case (in_cmd.mode)
            MODE_VTX: keep = (slot_ext < VTX_LIM);
            MODE_TRI: keep = (slot_ext < TRI_LIM);
            MODE_LOC: keep = 1'b1;
            default:  keep = 1'b0;
        endcase
    end

    assign q_push = push && !full && keep;

    tmpl_fifo #(
        .WIDTH($bits(cmd_t)),
        .DEPTH(4)
    ) u_cmd_q (
        .clk  (clk),
        .rst_n(rst_n),
        .push (q_push),
        .wdata(in_cmd),
        .pop  (cmd_pop),
        .rdata(cmd),
        .full (full),
        .empty(cmd_empty)
    );

endmodule
`default_nettype wire

@@ hdl/tmpl_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tmpl_back: store and search engine of the point locator
// Holds the vertex and triangle memories and runs the triangle scan.
// ----------------------------------------------------------------------------
module tmpl_back #(
    parameter int MAX_VERTICES  = 1024,
    parameter int MAX_TRIANGLES = 1024
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire tmpl_pkg::cmd_t              cmd,
    input  wire logic                        cmd_empty,
    output logic                             cmd_pop,
    input  wire logic [tmpl_pkg::CNT_W-1:0]  count,
    input  wire logic                        res_full,
    output logic                             res_push,
    output tmpl_pkg::res_t                   res
);
    import tmpl_pkg::*;

    localparam int VAW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int TAW = (MAX_TRIANGLES > 1) ? $clog2(MAX_TRIANGLES) : 1;
    localparam logic [16:0] VTX_LIM = 17'(MAX_VERTICES);
    localparam logic [16:0] TRI_LIM = 17'(MAX_TRIANGLES);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_TRI  = 4'd1;
    localparam logic [3:0] ST_VA   = 4'd2;
    localparam logic [3:0] ST_VB   = 4'd3;
    localparam logic [3:0] ST_VC   = 4'd4;
    localparam logic [3:0] ST_VD   = 4'd5;
    localparam logic [3:0] ST_MUL  = 4'd6;
    localparam logic [3:0] ST_ACC  = 4'd7;
    localparam logic [3:0] ST_CMP  = 4'd8;
    localparam logic [3:0] ST_RES  = 4'd9;

    logic [31:0] vmem [MAX_VERTICES];
    logic [29:0] tmem [MAX_TRIANGLES];

    logic [3:0]         state_reg;
    logic [16:0]        t_reg;
    logic [16:0]        n_reg;
    logic [31:0]        pt_reg;
    logic [29:0]        tri_reg;
    logic [31:0]        vrd_reg;
    logic               vok_reg;
    logic [31:0]        va_reg;
    logic [31:0]        vb_reg;
    logic [31:0]        vc_reg;
    logic [1:0]         step_reg;
    logic signed [33:0] prod1_reg;
    logic signed [33:0] prod2_reg;
    logic [34:0]        whole_reg;
    logic [36:0]        parts_reg;
    logic               found_reg;
    logic [SLOT_W-1:0]  idx_reg;

    logic [SLOT_W-1:0]  corner;
    logic               vrd_en;
    logic [31:0]        vsel;
    logic [16:0]        cnt_ext;
    logic [16:0]        n_sat;
    logic [31:0]        p;
    logic [31:0]        q;
    logic [31:0]        r;
    logic signed [16:0] a1;
    logic signed [16:0] a2;
    logic signed [16:0] b1;
    logic signed [16:0] b2;
    logic signed [34:0] diff;
    logic [34:0]        mag;

    assign cmd_pop  = (state_reg == ST_IDLE) && !cmd_empty;
    assign res_push = (state_reg == ST_RES) && !res_full;
    assign res.found          = found_reg;
    assign res.triangle_index = idx_reg;

    assign cnt_ext = {6'b0, count};
    assign n_sat   = (cnt_ext > TRI_LIM) ? TRI_LIM : cnt_ext;

    // A corner past the vertex store reads as the origin.
    assign vsel = vok_reg ? vrd_reg : 32'd0;

    always_comb
    begin
        case (state_reg)
            ST_VA:   corner = tri_reg[9:0];
            ST_VB:   corner = tri_reg[19:10];
            default: corner = tri_reg[29:20];
        endcase
    end
    assign vrd_en = (state_reg == ST_VA) || (state_reg == ST_VB) || (state_reg == ST_VC);

    always_ff @(posedge clk)
    begin
        if (cmd_pop && cmd.mode == MODE_VTX)
        begin
            vmem[VAW'(cmd.slot)] <= {cmd.coord_y, cmd.coord_x};
        end
        if (cmd_pop && cmd.mode == MODE_TRI)
        begin
            tmem[TAW'(cmd.slot)] <= {cmd.corner_c, cmd.corner_b, cmd.corner_a};
        end
        if (state_reg == ST_TRI)
        begin
            tri_reg <= tmem[t_reg[TAW-1:0]];
        end
        if (vrd_en)
        begin
            vrd_reg <= vmem[VAW'(corner)];
            vok_reg <= ({7'b0, corner} < VTX_LIM);
        end
    end

    // Step 0 is the whole triangle, steps 1 to 3 the sub-triangles through
    // the query point.
    always_comb
    begin
        case (step_reg)
            2'd0:    begin p = va_reg; q = vb_reg; r = vc_reg; end
            2'd1:    begin p = va_reg; q = pt_reg; r = vb_reg; end
            2'd2:    begin p = vb_reg; q = pt_reg; r = vc_reg; end
            default: begin p = vc_reg; q = pt_reg; r = va_reg; end
        endcase
        a1 = $signed({1'b0, p[15:0]})  - $signed({1'b0, q[15:0]});
        a2 = $signed({1'b0, p[31:16]}) - $signed({1'b0, q[31:16]});
        b1 = $signed({1'b0, p[15:0]})  - $signed({1'b0, r[15:0]});
        b2 = $signed({1'b0, p[31:16]}) - $signed({1'b0, r[31:16]});
        diff = prod1_reg - prod2_reg;
        mag  = diff[34] ? 35'(-diff) : 35'(diff);
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_MUL)
        begin
            prod1_reg <= a1 * b2;
            prod2_reg <= a2 * b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            t_reg     <= '0;
            n_reg     <= '0;
            pt_reg    <= '0;
            va_reg    <= '0;
            vb_reg    <= '0;
            vc_reg    <= '0;
            step_reg  <= '0;
            whole_reg <= '0;
            parts_reg <= '0;
            found_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (cmd_pop && cmd.mode == MODE_LOC)
                    begin
                        pt_reg    <= {cmd.coord_y, cmd.coord_x};
                        n_reg     <= n_sat;
                        t_reg     <= '0;
                        found_reg <= 1'b0;
                        idx_reg   <= '0;
                        state_reg <= (n_sat == '0) ? ST_RES : ST_TRI;
                    end
                end
                ST_TRI:
                begin
                    parts_reg <= '0;
                    step_reg  <= '0;
                    state_reg <= ST_VA;
                end
                ST_VA:   state_reg <= ST_VB;
                ST_VB:
                begin
                    va_reg    <= vsel;
                    state_reg <= ST_VC;
                end
                ST_VC:
                begin
                    vb_reg    <= vsel;
                    state_reg <= ST_VD;
                end
                ST_VD:
                begin
                    vc_reg    <= vsel;
                    state_reg <= ST_MUL;
                end
                ST_MUL:  state_reg <= ST_ACC;
                ST_ACC:
                begin
                    if (step_reg == 2'd0)
                    begin
                        whole_reg <= mag;
                    end
                    else
                    begin
                        parts_reg <= parts_reg + {2'b0, mag};
                    end
                    step_reg  <= step_reg + 1'b1;
                    state_reg <= (step_reg == 2'd3) ? ST_CMP : ST_MUL;
                end
                ST_CMP:
                begin
                    if (parts_reg == {2'b0, whole_reg})
                    begin
                        found_reg <= 1'b1;
                        idx_reg   <= t_reg[SLOT_W-1:0];
                        state_reg <= ST_RES;
                    end
                    else if (t_reg + 1'b1 == n_reg)
                    begin
                        state_reg <= ST_RES;
                    end
                    else
                    begin
                        t_reg     <= t_reg + 1'b1;
                        state_reg <= ST_TRI;
                    end
                end
                ST_RES:
                begin
                    if (!res_full)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

@@ hdl/triangle_mesh_point_locator.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// triangle_mesh_point_locator: finds the mesh triangle that holds a point
// Vertex and triangle stores plus a sequential scan over the stored triangles.
// ----------------------------------------------------------------------------
// Words enter through a push/full queue port and carry one of three modes:
// a vertex write, a triangle write or a point query. Writes produce no
// result; a query produces one result word (found, triangle_index) on the
// empty/pop side. A query tests triangles 0 to triangle_count-1 in order,
// each with exact integer area sums, so edges and corners count as inside,
// and reports the first hit. A front stage queues up to four commands while
// the search engine works, and a two-word result queue lets the engine move
// on while a result waits. The time the scan spends on each triangle is
// set by the single read port of the vertex memory (three corner reads
// after the triangle read) and by one shared pair of 17 by 17 multipliers
// that evaluates the four cross products one after another. triangle_count
// may only be written while no query is in flight; values above
// MAX_TRIANGLES scan the whole triangle store.
module triangle_mesh_point_locator #(
    parameter int MAX_VERTICES  = 1024,
    parameter int MAX_TRIANGLES = 1024
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [1:0]  mode,
    input  wire logic [9:0]  slot,
    input  wire logic [15:0] coord_x,
    input  wire logic [15:0] coord_y,
    input  wire logic [9:0]  corner_a,
    input  wire logic [9:0]  corner_b,
    input  wire logic [9:0]  corner_c,
    output logic             empty,
    input  wire logic        pop,
    output logic             found,
    output logic [9:0]       triangle_index,
    input  wire logic        cfg_wr_en,
    input  wire logic [10:0] cfg_wr_data
);
    import tmpl_pkg::*;

    logic [CNT_W-1:0] count_reg;
    cmd_t             in_cmd;
    cmd_t             cmd;
    logic             cmd_empty;
    logic             cmd_pop;
    logic             res_full;
    logic             res_push;
    res_t             res_in;
    res_t             res_out;

    // The triangle count register is the only configuration state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            count_reg <= cfg_wr_data;
        end
    end

    assign in_cmd.mode     = mode;
    assign in_cmd.slot     = slot;
    assign in_cmd.coord_x  = coord_x;
    assign in_cmd.coord_y  = coord_y;
    assign in_cmd.corner_a = corner_a;
    assign in_cmd.corner_b = corner_b;
    assign in_cmd.corner_c = corner_c;

    tmpl_front #(
        .MAX_VERTICES (MAX_VERTICES),
        .MAX_TRIANGLES(MAX_TRIANGLES)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .in_cmd   (in_cmd),
        .cmd_pop  (cmd_pop),
        .cmd      (cmd),
        .cmd_empty(cmd_empty)
    );

    tmpl_back #(
        .MAX_VERTICES (MAX_VERTICES),
        .MAX_TRIANGLES(MAX_TRIANGLES)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .cmd_empty(cmd_empty),
        .cmd_pop  (cmd_pop),
        .count    (count_reg),
        .res_full (res_full),
        .res_push (res_push),
        .res      (res_in)
    );

    // Results wait here so the engine can take the next command at once.
    tmpl_fifo #(
        .WIDTH($bits(res_t)),
        .DEPTH(2)
    ) u_res_q (
        .clk  (clk),
        .rst_n(rst_n),
        .push (res_push),
        .wdata(res_in),
        .pop  (pop && !empty),
        .rdata(res_out),
        .full (res_full),
        .empty(empty)
    );

    assign found          = res_out.found;
    assign triangle_index = res_out.triangle_index;

endmodule
`default_nettype wire
